[hw/rtl/frd_pkg.sv]
// shared constants for the record deframer: offset width, marker width,
// result kinds, register indexes and parse phase codes
// no dependencies
`timescale 1ns / 1ps

package frd_pkg;

   localparam int OFFSET_BITS = 48;
   localparam int MARKER_BITS = 64;
   localparam int COUNT_BITS  = 4;
   localparam int KIND_BITS   = 2;
   localparam int INDEX_BITS  = 2;

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [MARKER_BITS-1:0] marker_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [KIND_BITS-1:0]   kind_type;
   typedef logic [INDEX_BITS-1:0]  index_type;

   // result kinds
   localparam kind_type KIND_RECORD   = 2'd0;
   localparam kind_type KIND_PAST_END = 2'd1;
   localparam kind_type KIND_MISMATCH = 2'd2;

   // register indexes
   localparam index_type CSR_MARKER_EIGHT = 2'd0;
   localparam index_type CSR_BIG_ENDIAN   = 2'd1;
   localparam index_type CSR_FILE_SIZE    = 2'd2;

   // parse phases
   localparam logic [1:0] PH_HEAD    = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_TRAIL   = 2'd2;

endpackage

[hw/rtl/fortran_record_deframer_unit.sv]
// record deframer top level: splits a byte stream into length-framed records
// depends on frd_pkg
`timescale 1ns / 1ps

// Usage:
// req_ channel carries one file byte per item, in file order. csr_ channel
// writes marker width (index 0), marker byte order (index 1) and file size
// (index 2); write them while the block is idle, before the first byte of a
// file. csr_ready is always high.
// rsp_ channel gives at most one item per input byte: kind, offset, length.
// A good record is reported on the last byte of its trailing marker; errors
// are reported on the byte that exposes them, after which the rest of the
// file is skipped. Once the last byte of the file has been taken, the block
// is back at position zero for the next file.
// Path: a byte is held in the input register, then its result in the result
// register. Throughput: one byte per cycle while rsp is not stalled; the
// per-byte update is a single pass through the marker gather, a 48-bit
// remaining-bytes subtract and a 64-bit marker compare.
// Stall: a byte that yields no result passes even while rsp is stalled; a
// byte that yields a result waits in the input register, and req_ready drops
// when both registers are held.
// Reset: synchronous; configuration, valid and parse registers return to zero,
// phase to head marker, all items in flight are dropped; data fields are not reset.
module fortran_record_deframer_unit
   import frd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output kind_type   rsp_kind,
   output offset_type rsp_offset,
   output offset_type rsp_length,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  index_type  csr_index,
   input  offset_type csr_data
);

   function automatic marker_type gather(input marker_type acc, input logic [7:0] b,
                                         input logic big, input count_type cnt);
      logic [5:0] shamt;
      shamt = {cnt[2:0], 3'b000};
      if (big) begin
         gather = {acc[MARKER_BITS-9:0], b};
      end else begin
         gather = acc | ({{(MARKER_BITS-8){1'b0}}, b} << shamt);
      end
   endfunction

   function automatic marker_type sign_fix(input marker_type v, input logic eight);
      if (eight) begin
         sign_fix = v;
      end else begin
         sign_fix = {{(MARKER_BITS-32){v[31]}}, v[31:0]};
      end
   endfunction

   // configuration
   logic       eight_ff;
   logic       big_ff;
   offset_type size_ff;

   // input register
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_fire;

   // parse state
   offset_type pos_ff, pos_in;
   offset_type start_ff, start_in;
   marker_type head_ff, head_in;
   marker_type trail_ff, trail_in;
   count_type  cnt_ff, cnt_in;
   offset_type left_ff, left_in;
   logic [1:0] phase_ff, phase_in;
   logic       skip_ff, skip_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   kind_ff, kind_in;
   offset_type offset_ff, offset_in;
   offset_type length_ff, length_in;

   logic       has_result;
   logic       to_trail;
   logic [3:0] width_bytes;
   offset_type rem_bytes;
   offset_type after;
   logic       out_free;

   assign width_bytes = eight_ff ? 4'd8 : 4'd4;
   assign rem_bytes   = size_ff - pos_ff;
   assign after       = rem_bytes - {{(OFFSET_BITS-1){1'b0}}, 1'b1};
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign s1_fire     = s1_valid_ff && (!has_result || out_free);
   assign req_ready   = !s1_valid_ff || s1_fire;
   assign csr_ready   = 1'b1;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_offset = offset_ff;
   assign rsp_length = length_ff;

   always_comb begin
      pos_in     = pos_ff;
      start_in   = start_ff;
      head_in    = head_ff;
      trail_in   = trail_ff;
      cnt_in     = cnt_ff;
      left_in    = left_ff;
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      has_result = 1'b0;
      to_trail   = 1'b0;
      kind_in    = KIND_RECORD;
      offset_in  = start_ff;
      length_in  = '0;

      if (pos_ff >= size_ff) begin
         // byte beyond the file: drop it and start over
         pos_in   = '0;
         start_in = '0;
         head_in  = '0;
         trail_in = '0;
         cnt_in   = '0;
         left_in  = '0;
         phase_in = PH_HEAD;
         skip_in  = 1'b0;
      end else begin
         if (!skip_ff) begin
            unique case (phase_ff)
               PH_TRAIL: begin
                  trail_in = gather(trail_ff, s1_byte_ff, big_ff, cnt_ff);
                  cnt_in   = cnt_ff + 4'd1;
                  if (cnt_in >= width_bytes) begin
                     has_result = 1'b1;
                     if (sign_fix(trail_in, eight_ff) == head_ff) begin
                        kind_in   = KIND_RECORD;
                        offset_in = start_ff + {{(OFFSET_BITS-4){1'b0}}, width_bytes};
                        length_in = head_ff[OFFSET_BITS-1:0];
                     end else begin
                        kind_in = KIND_MISMATCH;
                        skip_in = 1'b1;
                     end
                     cnt_in   = '0;
                     phase_in = PH_HEAD;
                  end
               end
               PH_PAYLOAD: begin
                  if (left_ff != '0) begin
                     left_in = left_ff - {{(OFFSET_BITS-1){1'b0}}, 1'b1};
                  end
                  if (left_in == '0) begin
                     to_trail = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_HEAD;
                  if (cnt_ff == '0) begin
                     start_in = pos_ff;
                     head_in  = '0;
                     if (rem_bytes < {{(OFFSET_BITS-4){1'b0}}, width_bytes}) begin
                        // head marker cut short by the end of file
                        has_result = 1'b1;
                        kind_in    = KIND_PAST_END;
                        offset_in  = pos_ff;
                        skip_in    = 1'b1;
                     end
                  end
                  if (!skip_in) begin
                     head_in = gather(head_in, s1_byte_ff, big_ff, cnt_ff);
                     cnt_in  = cnt_ff + 4'd1;
                     if (cnt_in >= width_bytes) begin
                        head_in = sign_fix(head_in, eight_ff);
                        cnt_in  = '0;
                        if (head_in[MARKER_BITS-1] ||
                            head_in > {{(MARKER_BITS-OFFSET_BITS){1'b0}}, after}) begin
                           has_result = 1'b1;
                           kind_in    = KIND_PAST_END;
                           offset_in  = start_in;
                           skip_in    = 1'b1;
                        end else begin
                           left_in = head_in[OFFSET_BITS-1:0];
                           if (left_in == '0) begin
                              to_trail = 1'b1;
                           end else begin
                              phase_in = PH_PAYLOAD;
                           end
                        end
                     end
                  end
               end
            endcase
         end

         if (to_trail) begin
            cnt_in   = '0;
            trail_in = '0;
            if (after < {{(OFFSET_BITS-4){1'b0}}, width_bytes}) begin
               // no room left for the trailing marker
               has_result = 1'b1;
               kind_in    = KIND_MISMATCH;
               offset_in  = start_in;
               skip_in    = 1'b1;
               phase_in   = PH_HEAD;
            end else begin
               phase_in = PH_TRAIL;
            end
         end

         pos_in = pos_ff + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
         if (after == '0) begin
            // last byte of the file taken
            pos_in   = '0;
            start_in = '0;
            head_in  = '0;
            trail_in = '0;
            cnt_in   = '0;
            left_in  = '0;
            phase_in = PH_HEAD;
            skip_in  = 1'b0;
         end
      end

      if (s1_fire && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eight_ff     <= 1'b0;
         big_ff       <= 1'b0;
         size_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         start_ff     <= '0;
         head_ff      <= '0;
         trail_ff     <= '0;
         cnt_ff       <= '0;
         left_ff      <= '0;
         phase_ff     <= PH_HEAD;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MARKER_EIGHT) begin
               eight_ff <= csr_data[0];
            end
            if (csr_index == CSR_BIG_ENDIAN) begin
               big_ff <= csr_data[0];
            end
            if (csr_index == CSR_FILE_SIZE) begin
               size_ff <= csr_data;
            end
         end
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            pos_ff   <= pos_in;
            start_ff <= start_in;
            head_ff  <= head_in;
            trail_ff <= trail_in;
            cnt_ff   <= cnt_in;
            left_ff  <= left_in;
            phase_ff <= phase_in;
            skip_ff  <= skip_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
      end
      if (s1_fire && has_result) begin
         kind_ff   <= kind_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
      end
   end

   // while skipping, no marker is half gathered
   a_skip_idle: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (phase_ff == PH_HEAD && cnt_ff == '0))
      else $error("skip set with a marker in progress");

   // payload phase always has bytes left to count
   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (left_ff != '0))
      else $error("payload phase with nothing left");

   // a marker completes before its byte count passes eight
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < 4'd8)
      else $error("marker byte count out of range");

   // a produced result lands in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && has_result) |=> rsp_valid_ff)
      else $error("result lost on its way out");

endmodule
